>>> rtl/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
package rse_pkg;

	localparam int DATA_W          = 32;
	localparam int FUNC_W          = 3;
	localparam int DEPTH_W         = 7;
	localparam int ERR_W           = 2;
	localparam int STACK_DEPTH_DEF = 64;

	// token kinds; codes above FUNC_DIV are ignored
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
		logic                     first;
	} tok_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top;
		logic [DEPTH_W-1:0]       depth;
		logic [ERR_W-1:0]         error;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_WB,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/rpn_stack_evaluator.sv
// Push, ignored or rejected token: after acceptance the FSM goes to the emit state, which loads the result.
// Add, subtract, multiply, divide by zero: ALU, write-back, output load.
// Divide: read, then the one-bit-per-cycle divider, write-back, output load.
// One token at a time: the next token is taken the cycle after its result is loaded,
// so a token is only taken once the previous one is done; a held output stalls the result load.
// Reset clears the stack pointer and output valid; the stack RAM is not cleared.
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	output logic          tok_ready,
	input  rse_pkg::tok_t tok,
	output logic          res_valid,
	input  logic          res_ready,
	output rse_pkg::res_t res
);
	import rse_pkg::*;

	localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  sp_q;
	logic [PTR_W-1:0]  sp_eff;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] r_q;
	logic [FUNC_W-1:0] func_q;
	logic [ERR_W-1:0]  err_q;
	res_t              res_q;
	logic              res_valid_q;

	logic              tok_fire;
	logic              is_op;
	logic              full;
	logic              under;
	logic              push_ok;
	logic              op_go;
	logic              emit_load;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;
	logic [DATA_W-1:0] alu_r;
	logic [DATA_W-1:0] mem_rdata;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	assign tok_fire  = tok_valid && tok_ready;
	assign sp_eff    = tok.first ? '0 : sp_q;
	assign is_op     = (tok.func == FUNC_ADD) || (tok.func == FUNC_SUB) ||
	                   (tok.func == FUNC_MUL) || (tok.func == FUNC_DIV);
	assign full      = (sp_eff == PTR_W'(STACK_DEPTH));
	assign under     = (sp_eff < PTR_W'(2));
	assign push_ok   = tok_fire && (tok.func == FUNC_PUSH) && !full;
	assign op_go     = tok_fire && is_op && !under;
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || res_ready);
	assign div_start = (state_q == ST_READ) && (func_q == FUNC_DIV) && (top_q != '0);

	// operand a comes from the RAM, b is the cached top of stack
	always_comb begin
		unique case (func_q)
			FUNC_ADD: alu_r = mem_rdata + top_q;
			FUNC_SUB: alu_r = mem_rdata - top_q;
			FUNC_MUL: alu_r = mem_rdata * top_q;
			default:  alu_r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tok_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(sp_eff);
		mem_wdata = tok.value;
		mem_raddr = ADDR_W'(sp_eff - PTR_W'(2));
		unique case (state_q)
			ST_IDLE: begin
				tok_ready = 1'b1;
				mem_we    = push_ok;
				if (tok_fire) begin
					state_d = op_go ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: begin
				state_d = div_start ? ST_DIV : ST_WB;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(sp_q - PTR_W'(2));
				mem_wdata = r_q;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (tok_fire) begin
				sp_q <= push_ok ? (sp_eff + PTR_W'(1)) : sp_eff;
			end else if (state_q == ST_WB) begin
				sp_q <= sp_q - PTR_W'(1);
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_fire) begin
			func_q <= tok.func;
			if (tok.func == FUNC_PUSH && full) begin
				err_q <= ERR_FULL;
			end else if (is_op && under) begin
				err_q <= ERR_UNDER;
			end else begin
				err_q <= ERR_OK;
			end
		end
		if (push_ok) begin
			top_q <= tok.value;
		end else if (state_q == ST_WB) begin
			top_q <= r_q;
		end
		if (state_q == ST_READ) begin
			if (func_q == FUNC_DIV && top_q == '0) begin
				r_q   <= '0;
				err_q <= ERR_DIV0;
			end else begin
				r_q <= alu_r;
			end
		end else if (state_q == ST_DIV && div_done) begin
			r_q <= div_quot;
		end
		if (emit_load) begin
			res_q.top   <= (sp_q == '0) ? '0 : top_q;
			res_q.depth <= DEPTH_W'(sp_q);
			res_q.error <= err_q;
		end
	end

	rse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rse_div #(
		.WIDTH(DATA_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mem_rdata),
		.divisor (top_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PTR_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_wb_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> (sp_q >= PTR_W'(2)))
		else $error("write-back with fewer than two operands");

	a_wb_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |=> (sp_q == $past(sp_q) - PTR_W'(1)))
		else $error("operator write-back did not pop one entry");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

endmodule

>>> rtl/rse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/rse_div.sv
// Radix-2 restoring signed divider, truncating toward zero, one quotient bit per cycle.
module rse_div #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);
	import rse_pkg::*;

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;
	logic             neg_q;
	logic [WIDTH-1:0] rem_shift;
	logic [WIDTH:0]   diff;

	assign rem_shift = {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
	assign diff      = {1'b0, rem_shift} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes wrap, so the most negative value becomes 2^(WIDTH-1) unsigned
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
			den_q <= divisor[WIDTH-1] ? (~divisor + WIDTH'(1)) : divisor;
			neg_q <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
		end else if (busy_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + WIDTH'(1)) : quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("divider done without a finished run");

endmodule
